FILE: rtl/bscu_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types and constants for the compensation pipeline.
// ----------------------------------------------------------------------------
package bscu_pkg;

    localparam int DIV_CELLS  = 64;
    localparam int NUM_STAGES = 85;

    localparam logic [2:0] REG_T1     = 3'd0;
    localparam logic [2:0] REG_T2     = 3'd1;
    localparam logic [2:0] REG_T3     = 3'd2;
    localparam logic [2:0] REG_P1     = 3'd3;
    localparam logic [2:0] REG_P2_P3  = 3'd4;
    localparam logic [2:0] REG_P4_P5  = 3'd5;
    localparam logic [2:0] REG_P6_P7  = 3'd6;
    localparam logic [2:0] REG_P8_P9  = 3'd7;

    localparam logic [31:0] T_OFFSET   = 32'd128000;
    localparam logic [63:0] P_FULL     = 64'd1048576;
    localparam logic [63:0] P_SCALE    = 64'd3125;
    localparam logic [63:0] P_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [31:0] ROUND_HALF = 32'd128;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] den;
        logic        neg;
    } t_div;

    typedef struct packed {
        logic [19:0] raw_p;
        logic [31:0] fine;
        logic [31:0] cent;
        logic        zero;
    } t_side;

endpackage

FILE: rtl/bscu_if.sv
// ----------------------------------------------------------------------------
// Barometric compensation channels
// Valid/ready channels for readings, results and calibration writes.
// ----------------------------------------------------------------------------
interface bscu_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    modport source (output valid, raw_pressure, raw_temperature, input ready);
    modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bscu_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic signed [31:0] pressure_pa;
    logic               status;
    modport source (output valid, temperature_centi, fine_temperature, pressure_pa, status,
                    input ready);
    modport sink   (input valid, temperature_centi, fine_temperature, pressure_pa, status,
                    output ready);
endinterface

interface bscu_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/baro_sensor_compensation_unit.sv
// ----------------------------------------------------------------------------
// Barometric sensor compensation unit
// Integer temperature and pressure compensation of raw 20-bit readings.
//
//   channel | dir | payload
//   i_in    | in  | raw_pressure, raw_temperature
//   o_res   | out | temperature_centi, fine_temperature, pressure_pa, status
//   i_cfg   | in  | index, data (calibration words)
//
// One item per cycle while o_res is not stalled; the 64-cell divider row makes up most of the pipe.
// Any stall on o_res freezes the whole pipe; i_in.ready follows it.
// Reset clears the valid line and all calibration words to zero.
// i_cfg is always ready.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bscu_in_if.sink     i_in,
    bscu_res_if.source  o_res,
    bscu_cfg_if.sink    i_cfg
);
    import bscu_pkg::*;

    logic [15:0] r_t1, r_t2, r_t3, r_p1;
    logic [31:0] r_p23, r_p45, r_p67, r_p89;

    logic        en;
    logic        r_ovld;
    logic [NUM_STAGES:1] r_vld;
    t_side       r_side [1:NUM_STAGES];
    t_side       n_side [1:NUM_STAGES];

    logic [31:0] t2x, t3x;
    logic [63:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

    logic [31:0] r_x1, r_d, r_m1, r_dd, r_a, r_e, r_fine, f5;
    logic [63:0] r_v1, sq, v5, v2m, qp6, qp3, r_v5_d1, r_v5_d2, r_v2m_d1, r_v2m_d2;
    logic [63:0] r_v2, r_s, r_t, w, num, r_dv;
    t_div        r_dvin, dvout;
    logic [63:0] r_q, r_q_d1, r_q_d2, r_q_d3, r_q_d4, x, p8q, xx, m9, r_r2, r_r2d;
    logic [63:0] r_sum, r_pp, rnd;
    logic [31:0] r_cent, r_fine_o, r_pres;
    logic        r_stat;

    assign t2x = {{16{r_t2[15]}}, r_t2};
    assign t3x = {{16{r_t3[15]}}, r_t3};
    assign p1x = {48'd0, r_p1};
    assign p2x = {{48{r_p23[15]}}, r_p23[15:0]};
    assign p3x = {{48{r_p23[31]}}, r_p23[31:16]};
    assign p4x = {{48{r_p45[15]}}, r_p45[15:0]};
    assign p5x = {{48{r_p45[31]}}, r_p45[31:16]};
    assign p6x = {{48{r_p67[15]}}, r_p67[15:0]};
    assign p7x = {{48{r_p67[31]}}, r_p67[31:16]};
    assign p8x = {{48{r_p89[15]}}, r_p89[15:0]};
    assign p9x = {{48{r_p89[31]}}, r_p89[31:16]};

    // calibration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0; r_t2 <= '0; r_t3 <= '0; r_p1 <= '0;
            r_p23 <= '0; r_p45 <= '0; r_p67 <= '0; r_p89 <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_T1:    r_t1  <= i_cfg.data[15:0];
                REG_T2:    r_t2  <= i_cfg.data[15:0];
                REG_T3:    r_t3  <= i_cfg.data[15:0];
                REG_P1:    r_p1  <= i_cfg.data[15:0];
                REG_P2_P3: r_p23 <= i_cfg.data;
                REG_P4_P5: r_p45 <= i_cfg.data;
                REG_P6_P7: r_p67 <= i_cfg.data;
                REG_P8_P9: r_p89 <= i_cfg.data;
                default:   r_t1  <= r_t1;
            endcase
        end
    end

    // pipe control
    assign en          = !r_ovld || o_res.ready;
    assign i_in.ready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[NUM_STAGES-1:1], i_in.valid};
            r_ovld <= r_vld[NUM_STAGES];
        end
    end

    always_comb begin
        n_side[1] = '{raw_p: i_in.raw_pressure, fine: 32'd0, cent: 32'd0, zero: 1'b0};
        for (int k = 2; k <= NUM_STAGES; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[5].fine  = r_fine;
        n_side[5].cent  = 32'($signed(f5) >>> 8);
        n_side[13].zero = (w[63:33] == 31'd0);
    end

    assign f5 = r_fine + {r_fine[29:0], 2'b00} + ROUND_HALF;

    // temperature
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side <= n_side;
            r_x1   <= 32'(i_in.raw_temperature[19:3]) - 32'({r_t1, 1'b0});
            r_d    <= 32'(i_in.raw_temperature[19:4]) - 32'(r_t1);
            r_m1   <= r_x1 * t2x;
            r_dd   <= r_d * r_d;
            r_a    <= 32'($signed(r_m1) >>> 11);
            r_e    <= 32'($signed(r_dd) >>> 12) * t3x;
            r_fine <= r_a + 32'($signed(r_e) >>> 14);
            r_v1   <= {{32{r_fine[31]}}, r_fine} - 64'(T_OFFSET);
        end
    end

    // pressure
    bscu_mul64 u_sq  (.i_clk(i_clk), .i_en(en), .i_a(r_v1), .i_b(r_v1), .o_p(sq));
    bscu_mul64 u_m5  (.i_clk(i_clk), .i_en(en), .i_a(r_v1), .i_b(p5x),  .o_p(v5));
    bscu_mul64 u_m2  (.i_clk(i_clk), .i_en(en), .i_a(r_v1), .i_b(p2x),  .o_p(v2m));
    bscu_mul64 u_m6  (.i_clk(i_clk), .i_en(en), .i_a(sq),   .i_b(p6x),  .o_p(qp6));
    bscu_mul64 u_m3  (.i_clk(i_clk), .i_en(en), .i_a(sq),   .i_b(p3x),  .o_p(qp3));
    bscu_mul64 u_m1  (.i_clk(i_clk), .i_en(en), .i_a(r_s),  .i_b(p1x),  .o_p(w));
    bscu_mul64 u_mk  (.i_clk(i_clk), .i_en(en), .i_a(r_t),  .i_b(P_SCALE), .o_p(num));

    bscu_divider u_div (.i_clk(i_clk), .i_en(en), .i_d(r_dvin), .o_d(dvout));

    assign x = 64'($signed(r_q) >>> 13);

    bscu_mul64 u_m8  (.i_clk(i_clk), .i_en(en), .i_a(r_q),  .i_b(p8x),  .o_p(p8q));
    bscu_mul64 u_xx  (.i_clk(i_clk), .i_en(en), .i_a(x),    .i_b(x),    .o_p(xx));
    bscu_mul64 u_m9  (.i_clk(i_clk), .i_en(en), .i_a(xx),   .i_b(p9x),  .o_p(m9));

    assign rnd = r_pp + (r_pp[63] ? 64'd255 : 64'd0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v5_d1  <= v5;
            r_v5_d2  <= r_v5_d1;
            r_v2m_d1 <= v2m;
            r_v2m_d2 <= r_v2m_d1;
            r_v2     <= qp6 + {r_v5_d2[46:0], 17'd0} + {p4x[28:0], 35'd0};
            r_s      <= P_BIAS + 64'($signed(qp3) >>> 8) + {r_v2m_d2[51:0], 12'd0};
            r_t      <= ((P_FULL - 64'(r_side[10].raw_p)) << 31) - r_v2;
            r_dv     <= 64'($signed(w) >>> 33);
            r_dvin.rem <= 64'd0;
            r_dvin.quo <= num[63] ? (64'd0 - num) : num;
            r_dvin.den <= r_dv[63] ? (64'd0 - r_dv) : r_dv;
            r_dvin.neg <= num[63] ^ r_dv[63];
            r_q      <= dvout.neg ? (64'd0 - dvout.quo) : dvout.quo;
            r_q_d1   <= r_q;
            r_q_d2   <= r_q_d1;
            r_q_d3   <= r_q_d2;
            r_q_d4   <= r_q_d3;
            r_r2     <= 64'($signed(p8q) >>> 19);
            r_r2d    <= r_r2;
            r_sum    <= r_q_d4 + 64'($signed(m9) >>> 25) + r_r2d;
            r_pp     <= 64'($signed(r_sum) >>> 8) + {p7x[59:0], 4'd0};
            r_cent   <= r_side[NUM_STAGES].cent;
            r_fine_o <= r_side[NUM_STAGES].fine;
            r_stat   <= r_side[NUM_STAGES].zero;
            r_pres   <= r_side[NUM_STAGES].zero ? 32'd0 : rnd[39:8];
        end
    end

    assign o_res.valid             = r_ovld;
    assign o_res.temperature_centi = r_cent;
    assign o_res.fine_temperature  = r_fine_o;
    assign o_res.pressure_pa       = r_pres;
    assign o_res.status            = r_stat;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !o_res.ready) |-> !i_in.ready)
        else $error("input taken while output stalled");
    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[1])
        else $error("accepted item lost at pipe entry");
    a_error_zero_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status) |-> (o_res.pressure_pa == 32'd0))
        else $error("pressure not cleared on zero divisor");
`endif
endmodule

FILE: rtl/bscu_mul64.sv
// ----------------------------------------------------------------------------
// 64-bit wrapping multiplier
// Two stages: 32-bit partial products, then the final sum modulo 2^64.
// ----------------------------------------------------------------------------
module bscu_mul64 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;
    logic [31:0] n_mid;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0] * i_b[31:0];
            r_lh <= 32'(i_a[31:0] * i_b[63:32]);
            r_hl <= 32'(i_a[63:32] * i_b[31:0]);
            r_p  <= r_ll + {n_mid, 32'd0};
        end
    end

    assign n_mid = r_lh + r_hl;
    assign o_p   = r_p;
endmodule

FILE: rtl/bscu_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of the unsigned 64-bit division: one quotient bit.
// ----------------------------------------------------------------------------
module bscu_div_cell (
    input  logic            i_clk,
    input  logic            i_en,
    input  bscu_pkg::t_div  i_d,
    output bscu_pkg::t_div  o_d
);
    import bscu_pkg::*;

    t_div        r_d;
    t_div        n_d;
    logic [64:0] sh;
    logic [64:0] diff;

    always_comb begin
        sh   = {i_d.rem, i_d.quo[63]};
        diff = sh - {1'b0, i_d.den};
        n_d  = i_d;
        if (!diff[64]) begin
            n_d.rem = diff[63:0];
            n_d.quo = {i_d.quo[62:0], 1'b1};
        end else begin
            n_d.rem = sh[63:0];
            n_d.quo = {i_d.quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

FILE: rtl/bscu_divider.sv
// ----------------------------------------------------------------------------
// Divider chain
// Row of divider cells, one quotient bit per cell per cycle while i_en is high.
// ----------------------------------------------------------------------------
module bscu_divider (
    input  logic            i_clk,
    input  logic            i_en,
    input  bscu_pkg::t_div  i_d,
    output bscu_pkg::t_div  o_d
);
    import bscu_pkg::*;

    t_div chain [0:DIV_CELLS];

    assign chain[0] = i_d;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        bscu_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (chain[g]),
            .o_d   (chain[g+1])
        );
    end

    assign o_d = chain[DIV_CELLS];
endmodule
